FILE: design/assert_macros.svh
// Assertion helpers used by the converter's top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/r565yuv_pkg.sv
package r565yuv_pkg;

    // Fixed field widths.
    localparam int PIXEL_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 13;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset sizes.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Signed accumulator for the weighted sums.
    typedef logic signed [18:0] acc_t;

    // Weights over 256.
    localparam acc_t W_Y_R  = 19'sd77;
    localparam acc_t W_Y_G  = 19'sd150;
    localparam acc_t W_Y_B  = 19'sd29;
    localparam acc_t W_CR_R = 19'sd131;
    localparam acc_t W_CR_G = 19'sd110;
    localparam acc_t W_CR_B = 19'sd21;
    localparam acc_t W_CB_R = 19'sd29;
    localparam acc_t W_CB_G = 19'sd87;
    localparam acc_t W_CB_B = 19'sd131;
    localparam acc_t CHROMA_OFFSET = 19'sd32768;

    // Word held between the input register and the result register.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               chroma_en;
        logic               last;
    } stage_t;

    // Floor by 256 and clamp to a byte; negative sums give zero.
    function automatic logic [BYTE_W-1:0] clamp_byte(input acc_t sum);
        logic [10:0] q;
        q = sum[18:8];
        if (sum < 0)
            return '0;
        else if (q > 11'd255)
            return 8'd255;
        else
            return q[BYTE_W-1:0];
    endfunction

endpackage

FILE: design/rgb565_to_yuv420_semiplanar_top.sv
// RGB565 to YUV 4:2:0 semiplanar converter, chroma in V-then-U order.
// Input channel: in_valid / in_stall with one RGB565 pixel per word, raster order.
// Output channel: out_valid / out_stall; every pixel gives one word with its luma
// byte, and at even rows and even columns also a chroma pair (chroma_valid high,
// chroma_red then chroma_blue, taken from that pixel alone). frame_last marks the
// final pixel of the frame set by frame_width and frame_height (APB registers at
// byte addresses 0 and 4, sizes of 0 act as 1, above MAX_DIM as MAX_DIM).
// Pipeline: one input register that also captures position flags derived from the
// column and row counters, and one result register after the weighted sums and
// clamps, which drives out_valid. Throughput is one pixel per cycle while the
// receiver does not stall. When the receiver stalls, the result register holds
// and the input register fills; in_stall rises only when both are full and the
// output is stalled. Reset clears both pipeline stages and the counters and
// restores the sizes to 640 by 480. Sizes are to be written by the user only
// while the pipeline is empty; the block itself does not enforce this.
`include "assert_macros.svh"

module rgb565_to_yuv420_semiplanar_top
    import r565yuv_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Pixel input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [PIXEL_W-1:0]  pixel,
    // Result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   luma,
    output logic                chroma_valid,
    output logic [BYTE_W-1:0]   chroma_red,
    output logic [BYTE_W-1:0]   chroma_blue,
    output logic                frame_last,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SZ_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_DIM);

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [SZ_W-1:0]  width_eff, height_eff;
    logic [SZ_W-1:0]  col_inc, row_inc;
    logic             last_col, last_row;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic             out_valid_reg;
    logic [BYTE_W-1:0] luma_reg, chroma_red_reg, chroma_blue_reg;
    logic             chroma_valid_reg, frame_last_reg;

    logic             s2_ready, s1_ready, in_accept, cfg_write;

    // Register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size: zero acts as one, oversize as MAX_DIM.
    always_comb
    begin
        width_eff  = SZ_W'(frame_width_reg);
        height_eff = SZ_W'(frame_height_reg);
        if (frame_width_reg == '0)
            width_eff = SZ_W'(1);
        else if (width_eff > MAX_SZ)
            width_eff = MAX_SZ;
        if (frame_height_reg == '0)
            height_eff = SZ_W'(1);
        else if (height_eff > MAX_SZ)
            height_eff = MAX_SZ;
    end

    // Handshake: the result register frees when taken, the input register
    // frees when it moves on.
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // Column and row position of the accepted pixel.
    assign col_inc  = SZ_W'(col_cnt_reg) + SZ_W'(1);
    assign row_inc  = SZ_W'(row_cnt_reg) + SZ_W'(1);
    assign last_col = col_inc >= width_eff;
    assign last_row = row_inc >= height_eff;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_inc[CNT_W-1:0];
        end
        else
        begin
            col_cnt_next = col_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Input register: the pixel and its position flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.pixel     <= pixel;
            s1_reg.chroma_en <= !col_cnt_reg[0] && !row_cnt_reg[0];
            s1_reg.last      <= last_col && last_row;
        end
    end

    // Widened components and weighted sums.
    acc_t r8, g8, b8;
    acc_t y_sum, cr_sum, cb_sum;

    always_comb
    begin
        r8 = acc_t'({s1_reg.pixel[15:11], 3'b000});
        g8 = acc_t'({s1_reg.pixel[10:5], 2'b00});
        b8 = acc_t'({s1_reg.pixel[4:0], 3'b000});
        y_sum  = W_Y_R * r8 + W_Y_G * g8 + W_Y_B * b8;
        cr_sum = W_CR_R * r8 - W_CR_G * g8 - W_CR_B * b8 + CHROMA_OFFSET;
        cb_sum = W_CB_B * b8 - W_CB_R * r8 - W_CB_G * g8 + CHROMA_OFFSET;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            luma_reg         <= clamp_byte(y_sum);
            chroma_valid_reg <= s1_reg.chroma_en;
            chroma_red_reg   <= s1_reg.chroma_en ? clamp_byte(cr_sum) : '0;
            chroma_blue_reg  <= s1_reg.chroma_en ? clamp_byte(cb_sum) : '0;
            frame_last_reg   <= s1_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = chroma_valid_reg;
    assign chroma_red   = chroma_red_reg;
    assign chroma_blue  = chroma_blue_reg;
    assign frame_last   = frame_last_reg;

    // Checks on the pipeline and counters.
    `ASSERT_CLK(a_no_chroma_zero, clk, rst_n,
        (out_valid && !chroma_valid) |-> (chroma_red == '0 && chroma_blue == '0),
        "chroma bytes not zero on a luma-only word")
    `ASSERT_CLK(a_row_end_wraps, clk, rst_n,
        (in_accept && last_col) |=> (col_cnt_reg == '0),
        "column counter did not wrap at the end of a row")
    `ASSERT_CLK(a_stage_holds, clk, rst_n,
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_reg)),
        "input register changed while the output was blocked")
    `ASSERT_ALWAYS(a_ready_apb, clk,
        pready,
        "pready dropped")

endmodule

FILE: bench/rgb565_to_yuv420_semiplanar_top_tb.sv
`timescale 1ns / 100ps

module rgb565_to_yuv420_semiplanar_top_tb;
    import r565yuv_pkg::*;

    localparam int MAX_SIZE     = 4096;
    localparam int RANDOM_WORDS = 1650;

    // One output word as the converter presents it.
    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic              chroma_valid;
        logic [BYTE_W-1:0] chroma_red;
        logic [BYTE_W-1:0] chroma_blue;
        logic              frame_last;
    } yuv_word_t;

    // Predicts the YUV word of each accepted pixel and checks the words that come out.
    class nv21_checker;
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        int unsigned      column;
        int unsigned      row;
        yuv_word_t        expected_words[$];
        int               errors;

        function new();
            frame_width  = 13'd640;
            frame_height = 13'd480;
            column       = 0;
            row          = 0;
            errors       = 0;
        endfunction

        function int limit_size(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIZE)
                return MAX_SIZE;
            return int'(v);
        endfunction

        // Floor by 256 and saturate to a byte; a negative sum gives zero.
        function logic [BYTE_W-1:0] to_byte(int sum);
            if (sum < 0)
                return '0;
            if (sum / 256 > 255)
                return 8'd255;
            return 8'(sum / 256);
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px);
            int        r8;
            int        g8;
            int        b8;
            int        w;
            int        h;
            bit        even;
            bit        last_col;
            bit        last_row;
            yuv_word_t word;
            r8 = int'(px[15:11]) * 8;
            g8 = int'(px[10:5]) * 4;
            b8 = int'(px[4:0]) * 8;
            w = limit_size(frame_width);
            h = limit_size(frame_height);
            even = (column % 2 == 0) && (row % 2 == 0);
            last_col = (column + 1) >= w;
            last_row = (row + 1) >= h;

            word.luma = to_byte(77 * r8 + 150 * g8 + 29 * b8);
            word.chroma_valid = even;
            if (even)
            begin
                word.chroma_red  = to_byte(131 * r8 - 110 * g8 - 21 * b8 + 32768);
                word.chroma_blue = to_byte(-29 * r8 - 87 * g8 + 131 * b8 + 32768);
            end
            else
            begin
                word.chroma_red  = '0;
                word.chroma_blue = '0;
            end
            word.frame_last = last_col && last_row;
            expected_words.push_back(word);

            // Raster counters; a size change mid frame keeps the current position.
            if (last_col)
            begin
                column = 0;
                row = last_row ? 0 : row + 1;
            end
            else
            begin
                column = column + 1;
            end
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(yuv_word_t got);
            yuv_word_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("luma", want.luma, got.luma);
            compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
            compare_field("chroma_red", want.chroma_red, got.chroma_red);
            compare_field("chroma_blue", want.chroma_blue, got.chroma_blue);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [PIXEL_W-1:0]  pixel;
    logic                out_valid;
    logic                out_stall;
    logic [BYTE_W-1:0]   luma;
    logic                chroma_valid;
    logic [BYTE_W-1:0]   chroma_red;
    logic [BYTE_W-1:0]   chroma_blue;
    logic                frame_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    nv21_checker board;
    bit          calm;
    int          hold_request;
    int          random_sent;

    rgb565_to_yuv420_semiplanar_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .luma         (luma),
        .chroma_valid (chroma_valid),
        .chroma_red   (chroma_red),
        .chroma_blue  (chroma_blue),
        .frame_last   (frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none or short, a few long.
    function int pick_idle();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Receiver: random stall bursts, plus one long hold when requested.
    initial
    begin : receiver
        int stall_left;
        int flow_left;
        stall_left = 0;
        flow_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                flow_left = 0;
                hold_request = 0;
            end
            if (stall_left == 0 && flow_left == 0)
            begin
                if (calm)
                begin
                    flow_left = 16;
                end
                else
                begin
                    stall_left = pick_idle();
                    flow_left = $urandom_range(1, 8);
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                flow_left--;
            end
        end
    end

    // Check every word accepted at the output.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word({luma, chroma_valid, chroma_red, chroma_blue, frame_last});
    end

    // Offer one pixel, wait for acceptance, then idle for a gap chosen by pick_idle.
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pixel(px);
        gap = pick_idle();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            pixel <= PIXEL_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every expected word has come out.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write in setup and access cycles, only with the pipeline drained.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] size);
        logic [APB_W-1:0] value;
        wait_idle();
        value = $urandom;
        value[CFG_W-1:0] = size;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_FRAME_WIDTH)
            board.frame_width = size;
        else
            board.frame_height = size;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    function logic [CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 70)
            return CFG_W'($urandom_range(1, 8));
        if (roll < 92)
            return CFG_W'($urandom_range(9, 40));
        return CFG_W'($urandom_range(0, 8191));
    endfunction

    // Random pixel, often with components pinned at their extremes.
    function logic [PIXEL_W-1:0] pick_pixel();
        logic [PIXEL_W-1:0] px;
        px = PIXEL_W'($urandom);
        if ($urandom_range(0, 99) < 30)
        begin
            case ($urandom_range(0, 2))
                0: px[15:11] = $urandom_range(0, 1) ? 5'h1f : 5'h00;
                1: px[10:5] = $urandom_range(0, 1) ? 6'h3f : 6'h00;
                default: px[4:0] = $urandom_range(0, 1) ? 5'h1f : 5'h00;
            endcase
        end
        return px;
    endfunction

    // Main sequence.
    initial
    begin : stimulus
        logic [PIXEL_W-1:0] corners[12];
        int count;
        corners = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'hf81f,
                    16'h07ff, 16'hffe0, 16'h8410, 16'h0841, 16'haaaa, 16'h5555};
        board = new();
        calm = 1'b0;
        hold_request = 0;
        random_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Color extremes at the reset frame size, where chroma alternates on row zero.
        foreach (corners[i])
            send_pixel(corners[i]);

        // Shrink the frame mid row: the next pixel ends its row.
        set_frame(13'd2, 13'd2);
        repeat (4) send_pixel(pick_pixel());

        // Zero sizes act as one: every pixel ends a frame, and each after the first carries chroma.
        set_frame(13'd0, 13'd0);
        repeat (3) send_pixel(pick_pixel());

        set_frame(13'd3, 13'd3);
        repeat (5) send_pixel(pick_pixel());

        // Oversize widths and heights are limited, so a short run never wraps.
        set_frame(13'd8191, 13'd5000);
        repeat (24) send_pixel(pick_pixel());

        // Long receiver hold while the sender keeps offering, so the input stalls.
        calm = 1'b1;
        set_frame(13'd5, 13'd4);
        hold_request = 60;
        repeat (40) send_pixel(pick_pixel());
        random_sent = 40;
        calm = 1'b0;

        // Random phases with random frame sizes, some changing only one dimension.
        while (random_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 4))
                0: write_reg(REG_FRAME_WIDTH, pick_size());
                1: write_reg(REG_FRAME_HEIGHT, pick_size());
                default: set_frame(pick_size(), pick_size());
            endcase
            calm = ($urandom_range(0, 4) == 0);
            count = $urandom_range(30, 160);
            repeat (count) send_pixel(pick_pixel());
            random_sent += count;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/r565yuv_pkg.sv
design/rgb565_to_yuv420_semiplanar_top.sv
bench/rgb565_to_yuv420_semiplanar_top_tb.sv
